// ===== src/mmss_pkg.sv =====
// Package: sizes, command codes and shared control types of the int8 matrix product unit
`timescale 1ns / 1ps
`default_nettype none
package mmss_pkg;

    localparam int REDUCE_DEPTH = 64;
    localparam int COLUMNS      = 1024;

    localparam int CMD_W   = 2;
    localparam int DIDX_W  = 6;
    localparam int COL_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int PROD_W  = 2 * BYTE_W;
    localparam int ACC_W   = 32;

    localparam int RB_W    = (REDUCE_DEPTH > 1) ? $clog2(REDUCE_DEPTH) : 1;
    localparam int ADDR_W  = ((REDUCE_DEPTH * COLUMNS) > 1) ?
                             $clog2(REDUCE_DEPTH * COLUMNS) : 1;

    localparam int SAT_HI    = 127;
    localparam int SAT_LO    = -128;
    localparam int SHIFT_AMT = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_MATRIX = 2'd0,
        CMD_WR_ROW    = 2'd1,
        CMD_COMPUTE   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage
`default_nettype wire

// ===== src/mmss_store.sv =====
// Matrix store and row buffer memories with registered reads
`timescale 1ns / 1ps
`default_nettype none
module mmss_store
    import mmss_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_mat_we,
    input  wire logic [ADDR_W-1:0]        i_mat_waddr,
    input  wire logic signed [BYTE_W-1:0] i_mat_wdata,
    input  wire logic                     i_row_we,
    input  wire logic [RB_W-1:0]          i_row_waddr,
    input  wire logic signed [BYTE_W-1:0] i_row_wdata,
    input  wire logic [ADDR_W-1:0]        i_mat_raddr,
    input  wire logic [RB_W-1:0]          i_row_raddr,
    input  wire t_mac_ctl                 i_ctl,
    output logic signed [BYTE_W-1:0]      o_mat_rdata,
    output logic signed [BYTE_W-1:0]      o_row_rdata,
    output t_mac_ctl                      o_ctl
);

    logic signed [BYTE_W-1:0] r_mat [REDUCE_DEPTH * COLUMNS];
    logic signed [BYTE_W-1:0] r_row [REDUCE_DEPTH];
    logic signed [BYTE_W-1:0] r_mat_rdata;
    logic signed [BYTE_W-1:0] r_row_rdata;
    t_mac_ctl                 r_ctl;

    always_ff @(posedge i_clk) begin
        if (i_mat_we) begin
            r_mat[i_mat_waddr] <= i_mat_wdata;
        end
        r_mat_rdata <= r_mat[i_mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_row_we) begin
            r_row[i_row_waddr] <= i_row_wdata;
        end
        r_row_rdata <= r_row[i_row_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign o_mat_rdata = r_mat_rdata;
    assign o_row_rdata = r_row_rdata;
    assign o_ctl       = r_ctl;

endmodule
`default_nettype wire

// ===== src/mmss_mac.sv =====
// Shared multiply-accumulate unit with arithmetic shift and byte saturation
`timescale 1ns / 1ps
`default_nettype none
module mmss_mac
    import mmss_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [BYTE_W-1:0] i_a,
    input  wire logic signed [BYTE_W-1:0] i_b,
    output logic                          o_done,
    output logic signed [BYTE_W-1:0]      o_result
);

    t_mac_ctl                 r_ctl1;
    t_mac_ctl                 r_ctl2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  sh;
    logic signed [BYTE_W-1:0] sat;
    logic signed [BYTE_W-1:0] r_res;
    logic                     r_done;

    always_comb begin
        n_acc = r_ctl1.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        sh    = r_acc >>> SHIFT_AMT;
        if (sh > ACC_W'(SAT_HI)) begin
            sat = BYTE_W'(SAT_HI);
        end else if (sh < ACC_W'(SAT_LO)) begin
            sat = BYTE_W'(SAT_LO);
        end else begin
            sat = sh[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_ctl1.valid) begin
            r_acc <= n_acc;
        end
        if (r_ctl2.valid && r_ctl2.last) begin
            r_res <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= r_ctl2.valid && r_ctl2.last;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

// ===== src/int8_matmul_shift_saturate_unit.sv =====
// Top level: int8 matrix product engine with shift-by-six and byte saturation
//
// channel  direction  handshake            payload
// input    in         i_valid / o_stall    i_command, i_depth_index, i_column_index,
//                                          i_element_value
// output   out        o_valid / i_stall    o_product_out, o_column_out
//
// A write item is taken without raising o_stall. A compute item holds o_stall high during
// issue, one depth index at a time (one product per cycle through the single shared MAC),
// and then during memory read, multiply, accumulate, saturate and output load.
// Its result appears in the cycle o_stall falls; the next item is taken that cycle.
// Synchronous active-low reset clears control only; store contents are undefined.
// A result held by output stall keeps o_stall high for the next compute item.
`timescale 1ns / 1ps
`default_nettype none
module int8_matmul_shift_saturate_unit
    import mmss_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [CMD_W-1:0]         i_command,
    input  wire logic [DIDX_W-1:0]        i_depth_index,
    input  wire logic [COL_W-1:0]         i_column_index,
    input  wire logic signed [BYTE_W-1:0] i_element_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [BYTE_W-1:0]      o_product_out,
    output logic [COL_W-1:0]              o_column_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_PUT
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [RB_W-1:0]          r_k;
    logic [RB_W-1:0]          n_k;
    logic [ADDR_W-1:0]        r_addr;
    logic [ADDR_W-1:0]        n_addr;
    logic [COL_W-1:0]         r_col;
    logic [COL_W-1:0]         n_col;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [BYTE_W-1:0] r_out_prod;
    logic signed [BYTE_W-1:0] n_out_prod;
    logic [COL_W-1:0]         r_out_col;
    logic [COL_W-1:0]         n_out_col;

    logic                     accept;
    logic                     d_ok;
    logic                     c_ok;
    logic                     mat_we;
    logic                     row_we;
    logic [ADDR_W-1:0]        mat_waddr;
    logic                     k_last;
    t_mac_ctl                 issue_ctl;
    t_mac_ctl                 rd_ctl;
    logic signed [BYTE_W-1:0] mat_rdata;
    logic signed [BYTE_W-1:0] row_rdata;
    logic                     mac_done;
    logic signed [BYTE_W-1:0] mac_result;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign d_ok      = 32'(i_depth_index) < 32'(REDUCE_DEPTH);
    assign c_ok      = 32'(i_column_index) < 32'(COLUMNS);
    assign mat_waddr = ADDR_W'(32'(i_depth_index) * 32'(COLUMNS) + 32'(i_column_index));
    assign k_last    = r_k == RB_W'(REDUCE_DEPTH - 1);

    always_comb begin
        mat_we = 1'b0;
        row_we = 1'b0;
        if (accept) begin
            unique case (t_cmd'(i_command))
                CMD_WR_MATRIX: mat_we = d_ok && c_ok;
                CMD_WR_ROW:    row_we = d_ok;
                default:       ;
            endcase
        end
    end

    always_comb begin
        issue_ctl.valid = r_state == S_RUN;
        issue_ctl.first = r_k == '0;
        issue_ctl.last  = k_last;
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_addr      = r_addr;
        n_col       = r_col;
        n_out_valid = r_out_valid && i_stall;
        n_out_prod  = r_out_prod;
        n_out_col   = r_out_col;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_cmd'(i_command) == CMD_COMPUTE) && c_ok) begin
                    n_state = S_RUN;
                    n_k     = '0;
                    n_addr  = ADDR_W'(i_column_index);
                    n_col   = i_column_index;
                end
            end
            S_RUN: begin
                n_k    = r_k + RB_W'(1);
                n_addr = r_addr + ADDR_W'(COLUMNS);
                if (k_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (mac_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_prod  = mac_result;
                    n_out_col   = r_col;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_k        <= n_k;
        r_addr     <= n_addr;
        r_col      <= n_col;
        r_out_prod <= n_out_prod;
        r_out_col  <= n_out_col;
    end

    mmss_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mat_we    (mat_we),
        .i_mat_waddr (mat_waddr),
        .i_mat_wdata (i_element_value),
        .i_row_we    (row_we),
        .i_row_waddr (RB_W'(i_depth_index)),
        .i_row_wdata (i_element_value),
        .i_mat_raddr (r_addr),
        .i_row_raddr (r_k),
        .i_ctl       (issue_ctl),
        .o_mat_rdata (mat_rdata),
        .o_row_rdata (row_rdata),
        .o_ctl       (rd_ctl)
    );

    mmss_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rd_ctl),
        .i_a      (row_rdata),
        .i_b      (mat_rdata),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    assign o_stall       = r_state != S_IDLE;
    assign o_valid       = r_out_valid;
    assign o_product_out = r_out_prod;
    assign o_column_out  = r_out_col;

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_WAIT))
        else $error("result finished outside wait state");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && k_last |=> (r_state == S_WAIT))
        else $error("issue did not stop after last depth step");

    a_put_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) && r_out_valid && i_stall |=> (r_state == S_PUT))
        else $error("result overwrote a pending output item");
`endif

endmodule
`default_nettype wire
